[hw/rtl/serial_bank_switch_mapper_core_assert.svh]
// assertion macros for the serial bank switch mapper checker
// depends on clk and rst_n being visible where the macros are used
`ifndef SERIAL_BANK_SWITCH_MAPPER_CORE_ASSERT_SVH
`define SERIAL_BANK_SWITCH_MAPPER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SBSM_ASSERT_NOW(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SBSM_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

[hw/rtl/sbsm_pkg.sv]
// shared types and constants of the serial bank switch mapper
// no dependencies
package sbsm_pkg;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int MEM_ADDR_W   = 18;
    localparam int SHIFT_W      = 5;
    localparam int COUNT_W      = 3;
    localparam int PRG_BANK_W   = 4;
    localparam int CHR_BANK_W   = 5;
    localparam int PRG_OFS_W    = 14;
    localparam int CHR_OFS_W    = 12;
    localparam int CHR_SPACE_W  = 13;
    localparam int BANK_COUNT_W = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 5;

    // request types
    localparam logic [1:0] REQ_PRG_READ  = 2'd0;
    localparam logic [1:0] REQ_PRG_WRITE = 2'd1;
    localparam logic [1:0] REQ_CHR_READ  = 2'd2;
    localparam logic [1:0] REQ_CHR_WRITE = 2'd3;

    // memory targets
    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_PRG_ROM = 2'd1;
    localparam logic [1:0] TGT_CHR_ROM = 2'd2;
    localparam logic [1:0] TGT_CHR_RAM = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_USES_RAM   = 1'b1;

    localparam logic [BANK_COUNT_W-1:0] BANK_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [MEM_ADDR_W-1:0] mem_address;
        logic [1:0]            mem_target;
        logic                  mem_write;
        logic [1:0]            mirroring;
        logic                  mirroring_changed;
    } rsp_t;

    typedef struct packed {
        logic [BANK_COUNT_W-1:0] prg_bank_count;
        logic                    chr_uses_ram;
    } cfg_t;

endpackage

[hw/rtl/sbsm_map.sv]
// mapper state (serial shift register, bank registers) and address translation
// depends on sbsm_pkg
module sbsm_map
    import sbsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  req_t req,
    input  cfg_t cfg,
    output rsp_t rsp
);

    // target register picked by address bits 14:13 on the fifth write
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG      = 2'd3;

    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;
    localparam logic [COUNT_W-1:0] LAST_SHIFT = 3'd4;

    logic [SHIFT_W-1:0]    shift_reg, shift_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [1:0]            mirror_reg, mirror_next;
    logic                  chr_mode_reg, chr_mode_next;
    logic [1:0]            prg_mode_reg, prg_mode_next;
    logic [CHR_BANK_W-1:0] chr_low_reg, chr_low_next;
    logic [CHR_BANK_W-1:0] chr_high_reg, chr_high_next;
    logic [PRG_BANK_W-1:0] prg_bank_reg, prg_bank_next;

    logic [PRG_BANK_W-1:0]  last_bank;
    logic [PRG_BANK_W-1:0]  prg_win_low, prg_win_high, prg_bank;
    logic [CHR_BANK_W-1:0]  chr_win_low, chr_win_high, chr_bank;
    logic [SHIFT_W-1:0]     shifted;
    logic [CHR_SPACE_W-1:0] chr_addr;

    // last bank, with the count clamped to 1..16
    always_comb
    begin
        if (cfg.prg_bank_count == '0)
        begin
            last_bank = '0;
        end
        else if (cfg.prg_bank_count >= BANK_COUNT_RESET)
        begin
            last_bank = '1;
        end
        else
        begin
            last_bank = PRG_BANK_W'(cfg.prg_bank_count - 5'd1);
        end
    end

    // bank windows follow the registers directly
    always_comb
    begin
        unique case (prg_mode_reg) inside
            2'd0, 2'd1:
            begin
                prg_win_low  = {prg_bank_reg[PRG_BANK_W-1:1], 1'b0};
                prg_win_high = {prg_bank_reg[PRG_BANK_W-1:1], 1'b1};
            end
            PRG_MODE_FIX_FIRST:
            begin
                prg_win_low  = '0;
                prg_win_high = prg_bank_reg;
            end
            default:
            begin
                prg_win_low  = prg_bank_reg;
                prg_win_high = last_bank;
            end
        endcase
        if (!chr_mode_reg)
        begin
            chr_win_low  = {chr_low_reg[CHR_BANK_W-1:1], 1'b0};
            chr_win_high = {chr_low_reg[CHR_BANK_W-1:1], 1'b1};
        end
        else
        begin
            chr_win_low  = chr_low_reg;
            chr_win_high = chr_high_reg;
        end
    end

    always_comb
    begin
        shift_next    = shift_reg;
        count_next    = count_reg;
        mirror_next   = mirror_reg;
        chr_mode_next = chr_mode_reg;
        prg_mode_next = prg_mode_reg;
        chr_low_next  = chr_low_reg;
        chr_high_next = chr_high_reg;
        prg_bank_next = prg_bank_reg;

        rsp = '0;

        shifted  = {req.write_data[0], shift_reg[SHIFT_W-1:1]};
        chr_addr = req.address[CHR_SPACE_W-1:0];
        prg_bank = req.address[PRG_OFS_W] ? prg_win_high : prg_win_low;
        chr_bank = chr_addr[CHR_OFS_W] ? chr_win_high : chr_win_low;

        case (req.req_type)
            REQ_PRG_READ:
            begin
                if (req.address[ADDR_W-1])
                begin
                    rsp.mem_address = {prg_bank, req.address[PRG_OFS_W-1:0]};
                    rsp.mem_target  = TGT_PRG_ROM;
                end
            end
            REQ_PRG_WRITE:
            begin
                if (req.address[ADDR_W-1])
                begin
                    if (req.write_data[DATA_W-1])
                    begin
                        // reset write
                        shift_next    = '0;
                        count_next    = '0;
                        prg_mode_next = PRG_MODE_FIX_LAST;
                    end
                    else if (count_reg == LAST_SHIFT)
                    begin
                        shift_next = '0;
                        count_next = '0;
                        unique case (req.address[PRG_OFS_W:PRG_OFS_W-1])
                            SEL_CONTROL:
                            begin
                                mirror_next   = shifted[1:0];
                                prg_mode_next = shifted[3:2];
                                chr_mode_next = shifted[4];
                                rsp.mirroring_changed = 1'b1;
                            end
                            SEL_CHR_LOW:  chr_low_next  = shifted;
                            SEL_CHR_HIGH: chr_high_next = shifted;
                            SEL_PRG:      prg_bank_next = shifted[PRG_BANK_W-1:0];
                            default:      prg_bank_next = prg_bank_reg;
                        endcase
                    end
                    else
                    begin
                        shift_next = shifted;
                        count_next = count_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                if (cfg.chr_uses_ram)
                begin
                    rsp.mem_address = {{(MEM_ADDR_W-CHR_SPACE_W){1'b0}}, chr_addr};
                    rsp.mem_target  = TGT_CHR_RAM;
                    rsp.mem_write   = (req.req_type == REQ_CHR_WRITE);
                end
                else if (req.req_type == REQ_CHR_READ)
                begin
                    rsp.mem_address = {{(MEM_ADDR_W-CHR_BANK_W-CHR_OFS_W){1'b0}},
                                       chr_bank, chr_addr[CHR_OFS_W-1:0]};
                    rsp.mem_target  = TGT_CHR_ROM;
                end
            end
        endcase

        rsp.mirroring = mirror_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            count_reg    <= '0;
            mirror_reg   <= '0;
            chr_mode_reg <= 1'b0;
            prg_mode_reg <= PRG_MODE_FIX_LAST;
            chr_low_reg  <= '0;
            chr_high_reg <= '0;
            prg_bank_reg <= '0;
        end
        else if (accept)
        begin
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            mirror_reg   <= mirror_next;
            chr_mode_reg <= chr_mode_next;
            prg_mode_reg <= prg_mode_next;
            chr_low_reg  <= chr_low_next;
            chr_high_reg <= chr_high_next;
            prg_bank_reg <= prg_bank_next;
        end
    end

endmodule

[hw/rtl/serial_bank_switch_mapper_core.sv]
// top level of the serial bank switch mapper: config registers, mapper, output buffer
// depends on sbsm_pkg and sbsm_map
//
// Serial bank-switching cartridge mapper. Each input transaction is one CPU or
// PPU bus access; each gives exactly one output transaction carrying the
// translated offset into program ROM, character ROM or character RAM, the
// write strobe for character RAM and the mirroring mode after the access.
// CPU writes at 0x8000 and above feed the 5-bit serial register; the fifth
// write loads control, CHR bank 0, CHR bank 1 or the PRG bank by address, and
// a write with bit 7 set restarts the sequence and selects PRG mode 3.
// Throughput is one transaction per clock when not stalled: translation and the
// register update are one level of mux logic from the accepted request into
// the output register, or the skid register while that is held. A two-entry
// output buffer (output register plus skid register) lets input keep flowing
// while a result waits; in_stall is a registered flag and rises only once
// both entries are full. Configuration writes take effect on the next access.
module serial_bank_switch_mapper_core
    import sbsm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // bus access transactions in
    input  logic                   in_valid,
    output logic                   in_stall,
    input  req_t                   in_item,

    // translated transactions out
    output logic                   out_valid,
    input  logic                   out_stall,
    output rsp_t                   out_item
);

    cfg_t cfg_reg;
    rsp_t map_rsp;
    rsp_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;
    logic push, pop;

    // config registers; the user must write them only while idle; the block has no guard
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_bank_count <= BANK_COUNT_RESET;
            cfg_reg.chr_uses_ram   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PRG_BANK_COUNT: cfg_reg.prg_bank_count <= cfg_data;
                CFG_CHR_USES_RAM:   cfg_reg.chr_uses_ram   <= cfg_data[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // skid entry only fills while the output register is held,
    // so a free skid slot always means room for one more transaction
    assign in_stall = skid_valid_reg;
    assign push     = in_valid && !skid_valid_reg;
    assign pop      = out_valid_reg && !out_stall;

    sbsm_map u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (push),
        .req    (in_item),
        .cfg    (cfg_reg),
        .rsp    (map_rsp)
    );

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // drain skid into the output register
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            // output held: park the new result
            skid_valid_reg <= 1'b1;
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            if (push)
            begin
                out_reg <= map_rsp;
            end
        end
        else if (push)
        begin
            skid_reg <= map_rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

[hw/rtl/sbsm_checker.sv]
// port-level checker for the serial bank switch mapper, with its bind
// depends on sbsm_pkg and serial_bank_switch_mapper_core_assert.svh
`include "serial_bank_switch_mapper_core_assert.svh"

module sbsm_checker
    import sbsm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_write,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data,
    input logic                   in_valid,
    input logic                   in_stall,
    input req_t                   in_item,
    input logic                   out_valid,
    input logic                   out_stall,
    input rsp_t                   out_item
);

    // a held result stays put
    `SBSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_item), "output transaction changed while stalled")

    // input only backs up when a result is already waiting
    `SBSM_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid,
        "input stalled with empty output")

    `SBSM_ASSERT_NOW(a_write_is_ram, out_valid && out_item.mem_write,
        out_item.mem_target == TGT_CHR_RAM, "write strobe outside character ram")

    `SBSM_ASSERT_NOW(a_none_zero, out_valid && out_item.mem_target == TGT_NONE,
        out_item.mem_address == '0 && !out_item.mem_write, "unused access not cleared")

    `SBSM_ASSERT_NOW(a_ram_range, out_valid && out_item.mem_target == TGT_CHR_RAM,
        out_item.mem_address[MEM_ADDR_W-1:CHR_SPACE_W] == '0,
        "character ram offset beyond 8KB")

endmodule

bind serial_bank_switch_mapper_core sbsm_checker u_checker (.*);

[tb/serial_bank_switch_mapper_core_test.sv]
// self-checking testbench for serial_bank_switch_mapper_core: directed table, then random bus accesses
// depends on sbsm_pkg and the serial_bank_switch_mapper_core rtl
module serial_bank_switch_mapper_core_test;
    import sbsm_pkg::*;

    // nametable mirroring codes as carried in the mirroring field
    localparam logic [1:0] MIR_ONE_LOW    = 2'd0;
    localparam logic [1:0] MIR_ONE_HIGH   = 2'd1;
    localparam logic [1:0] MIR_VERTICAL   = 2'd2;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd3;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 85;
    localparam int HOLD_CYCLES   = 48;
    localparam int PRESSURE_RUN  = 24;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 4;
    localparam int DIRECTED_ROWS = 25;

    // bank counts and character ram choice per random phase; includes the clamped extremes
    localparam logic [4:0] PHASE_BANKS [PHASES] =
        '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd9, 5'd16};
    localparam logic PHASE_RAM [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    // one row of the directed table: the access, and its result where it is obvious
    typedef struct packed {
        req_t access;
        logic typed;
        rsp_t result;
    } access_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    req_t in_item;
    logic out_valid;
    logic out_stall;
    rsp_t out_item;

    // typed expectation travels alongside the payload so the monitor picks it up race-free
    logic typed_valid;
    rsp_t typed_result;

    // shadow copy of the mapper state and registers
    logic [4:0] shift_bits;
    logic [2:0] shift_len;
    logic [1:0] mirror_sel;
    logic       chr_split;
    logic [1:0] prg_layout;
    logic [4:0] chr_bank_a;
    logic [4:0] chr_bank_b;
    logic [3:0] prg_bank_sel;
    logic [4:0] chr_win_lo;
    logic [4:0] chr_win_hi;
    logic [3:0] prg_win_lo;
    logic [3:0] prg_win_hi;
    logic [4:0] bank_count_shadow;
    logic       chr_ram_shadow;

    rsp_t pending_results[$];

    // run control shared between the sender and the receiver
    bit calm;
    bit pressing;
    bit hold_off_req;

    int fault_count;
    int accepted_count;
    int checked_count;
    int control_loads;
    int stall_cycles;
    int settings_count;

    access_row_t directed [DIRECTED_ROWS] = '{
        // after reset: prg mode 3, last bank 15 at 0xc000, chr 8k at bank 0
        '{'{REQ_PRG_READ,  16'h8000, 8'h00}, 1'b1, '{18'h00000, TGT_PRG_ROM, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_PRG_READ,  16'hC000, 8'h00}, 1'b1, '{18'h3C000, TGT_PRG_ROM, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_PRG_READ,  16'hFFFF, 8'hFF}, 1'b1, '{18'h3FFFF, TGT_PRG_ROM, 1'b0, MIR_ONE_LOW, 1'b0}},
        // below the rom window nothing is selected
        '{'{REQ_PRG_READ,  16'h7FFF, 8'h00}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_PRG_READ,  16'h0000, 8'h00}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_CHR_READ,  16'h0000, 8'h00}, 1'b1, '{18'h00000, TGT_CHR_ROM, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_CHR_READ,  16'h1FFF, 8'h00}, 1'b1, '{18'h01FFF, TGT_CHR_ROM, 1'b0, MIR_ONE_LOW, 1'b0}},
        // ppu address above 8191 wraps to its low 13 bits
        '{'{REQ_CHR_READ,  16'hFFFF, 8'h00}, 1'b1, '{18'h01FFF, TGT_CHR_ROM, 1'b0, MIR_ONE_LOW, 1'b0}},
        // character write against rom is dropped
        '{'{REQ_CHR_WRITE, 16'h0123, 8'hFF}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        // cpu write below 0x8000 is ignored, then a restart write
        '{'{REQ_PRG_WRITE, 16'h7FFF, 8'h01}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_PRG_WRITE, 16'h8000, 8'h80}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        // control load of 5'b11011: chr 4k mode, prg mode 2, horizontal, lsb first
        '{'{REQ_PRG_WRITE, 16'h8000, 8'h7F}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_PRG_WRITE, 16'h9FFF, 8'h01}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_PRG_WRITE, 16'h8123, 8'h7E}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_PRG_WRITE, 16'h9000, 8'h01}, 1'b1, '{18'h00000, TGT_NONE, 1'b0, MIR_ONE_LOW, 1'b0}},
        '{'{REQ_PRG_WRITE, 16'h9FFF, 8'h01}, 1'b1,
            '{18'h00000, TGT_NONE, 1'b0, MIR_HORIZONTAL, 1'b1}},
        // chr bank 1 loaded with all ones
        '{'{REQ_PRG_WRITE, 16'hDFFF, 8'h01}, 1'b0, '0},
        '{'{REQ_PRG_WRITE, 16'hC000, 8'h01}, 1'b0, '0},
        '{'{REQ_PRG_WRITE, 16'hD555, 8'h01}, 1'b0, '0},
        '{'{REQ_PRG_WRITE, 16'hCAAA, 8'h01}, 1'b0, '0},
        '{'{REQ_PRG_WRITE, 16'hDFFF, 8'h01}, 1'b0, '0},
        '{'{REQ_CHR_READ,  16'h1FFF, 8'h00}, 1'b0, '0},
        '{'{REQ_PRG_READ,  16'h8000, 8'h00}, 1'b0, '0},
        '{'{REQ_PRG_READ,  16'hFFFF, 8'h00}, 1'b0, '0},
        // restart write forces prg mode 3 again
        '{'{REQ_PRG_WRITE, 16'hE000, 8'hFF}, 1'b0, '0}
    };

    serial_bank_switch_mapper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #400000;
        $display("serial_bank_switch_mapper_core verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // shadow model of the mapper
    // ---------------------------------------------------------------

    // bank count clamped to 1..16, last bank index
    function automatic logic [3:0] last_prg_bank();
        logic [4:0] n;
        n = bank_count_shadow;
        if (n == 5'd0)
            n = 5'd1;
        if (n > 5'd16)
            n = 5'd16;
        return 4'(n - 5'd1);
    endfunction

    function automatic void refresh_prg_windows();
        case (prg_layout)
            2'd0, 2'd1:
            begin
                // 32k mode ignores the low bank bit
                prg_win_lo = {prg_bank_sel[3:1], 1'b0};
                prg_win_hi = {prg_bank_sel[3:1], 1'b1};
            end
            2'd2:
            begin
                prg_win_lo = 4'd0;
                prg_win_hi = prg_bank_sel;
            end
            default:
            begin
                prg_win_lo = prg_bank_sel;
                prg_win_hi = last_prg_bank();
            end
        endcase
    endfunction

    function automatic void refresh_chr_windows();
        if (!chr_split)
        begin
            chr_win_lo = {chr_bank_a[4:1], 1'b0};
            chr_win_hi = {chr_bank_a[4:1], 1'b1};
        end
        else
        begin
            chr_win_lo = chr_bank_a;
            chr_win_hi = chr_bank_b;
        end
    endfunction

    function automatic void reset_shadow();
        shift_bits        = '0;
        shift_len         = '0;
        mirror_sel        = MIR_ONE_LOW;
        chr_split         = 1'b0;
        prg_layout        = 2'd3;
        chr_bank_a        = '0;
        chr_bank_b        = '0;
        prg_bank_sel      = '0;
        bank_count_shadow = BANK_COUNT_RESET;
        chr_ram_shadow    = 1'b0;
        refresh_prg_windows();
        refresh_chr_windows();
    endfunction

    function automatic void apply_setting(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_PRG_BANK_COUNT:
            begin
                bank_count_shadow = value;
                refresh_prg_windows();
            end
            CFG_CHR_USES_RAM: chr_ram_shadow = value[0];
            default: ;
        endcase
    endfunction

    // serial port write at 0x8000 and up; returns 1 when a control load completes
    function automatic logic shift_in(input logic [15:0] addr, input logic [7:0] data);
        logic loaded_control;
        loaded_control = 1'b0;
        if (data[7])
        begin
            shift_bits = '0;
            shift_len  = '0;
            prg_layout = 2'd3;
            refresh_prg_windows();
            return 1'b0;
        end
        shift_bits = {data[0], shift_bits[4:1]};
        shift_len  = shift_len + 3'd1;
        if (shift_len < 3'd5)
            return 1'b0;
        // address bits 14:13 pick control, chr bank 0, chr bank 1, prg bank
        case (addr[14:13])
            2'd0:
            begin
                mirror_sel     = shift_bits[1:0];
                prg_layout     = shift_bits[3:2];
                chr_split      = shift_bits[4];
                loaded_control = 1'b1;
            end
            2'd1: chr_bank_a = shift_bits;
            2'd2: chr_bank_b = shift_bits;
            default: prg_bank_sel = shift_bits[3:0];
        endcase
        refresh_prg_windows();
        refresh_chr_windows();
        shift_bits = '0;
        shift_len  = '0;
        return loaded_control;
    endfunction

    // translate one bus access and advance the shadow state
    function automatic rsp_t map_access(input req_t r);
        rsp_t res;
        logic [3:0] pbank;
        logic [4:0] cbank;
        logic [12:0] caddr;
        res   = '0;
        caddr = r.address[12:0];
        case (r.req_type)
            REQ_PRG_READ:
            begin
                if (r.address[15])
                begin
                    pbank = r.address[14] ? prg_win_hi : prg_win_lo;
                    res.mem_address = {pbank, r.address[13:0]};
                    res.mem_target  = TGT_PRG_ROM;
                end
            end
            REQ_PRG_WRITE:
            begin
                if (r.address[15])
                    res.mirroring_changed = shift_in(r.address, r.write_data);
            end
            default:
            begin
                if (chr_ram_shadow)
                begin
                    res.mem_address = 18'(caddr);
                    res.mem_target  = TGT_CHR_RAM;
                    res.mem_write   = (r.req_type == REQ_CHR_WRITE);
                end
                else if (r.req_type == REQ_CHR_READ)
                begin
                    cbank = caddr[12] ? chr_win_hi : chr_win_lo;
                    res.mem_address = {1'b0, cbank, caddr[11:0]};
                    res.mem_target  = TGT_CHR_ROM;
                end
            end
        endcase
        res.mirroring = mirror_sel;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_fault(input string what, input longint want, input longint got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch %s at result %0d: expected 0x%0h, got 0x%0h",
                     what, checked_count, want, got);
    endtask

    task automatic compare_result(input rsp_t want, input rsp_t got);
        if (got.mem_address !== want.mem_address)
            report_fault("mem_address", want.mem_address, got.mem_address);
        if (got.mem_target !== want.mem_target)
            report_fault("mem_target", want.mem_target, got.mem_target);
        if (got.mem_write !== want.mem_write)
            report_fault("mem_write", want.mem_write, got.mem_write);
        if (got.mirroring !== want.mirroring)
            report_fault("mirroring", want.mirroring, got.mirroring);
        if (got.mirroring_changed !== want.mirroring_changed)
            report_fault("mirroring_changed", want.mirroring_changed, got.mirroring_changed);
    endtask

    // everything is sampled at the clock edge, before any driver update lands;
    // the output is checked first so a same-edge push can never be popped early
    always @(posedge clk)
    begin : scoreboard
        rsp_t want;
        rsp_t got;
        rsp_t predicted;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = out_item;
                if (pending_results.size() == 0)
                    report_fault("result with no transaction pending", 0, got);
                else
                begin
                    want = pending_results.pop_front();
                    compare_result(want, got);
                end
                checked_count++;
                if (got.mirroring_changed === 1'b1)
                    control_loads++;
            end
            if (cfg_write)
                apply_setting(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                // the shadow state advances on every accepted transaction, typed or not
                predicted = map_access(in_item);
                pending_results.push_back(typed_valid ? typed_result : predicted);
                accepted_count++;
            end
            if (in_stall)
                stall_cycles++;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall bursts, one long hold-off on request, none when calm
    // ---------------------------------------------------------------

    initial
    begin : receiver
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                // long hold-off so the two-entry output buffer fills and in_stall rises
                out_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    function automatic req_t bus_access(input logic [1:0] kind, input logic [15:0] addr,
                                        input logic [7:0] data);
        req_t r;
        r.req_type   = kind;
        r.address    = addr;
        r.write_data = data;
        return r;
    endfunction

    // offer one transaction and hold it until accepted
    task automatic offer(input req_t r, input logic typed, input rsp_t want);
        if (!pressing && !calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_item      <= r;
        typed_valid  <= typed;
        typed_result <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic offer_random(input req_t r);
        offer(r, 1'b0, '0);
    endtask

    // five serial writes into one register window, sometimes with a restart up front,
    // reads mixed in, or broken by a restart in the middle
    task automatic serial_load(inout int sent);
        logic [1:0] region;
        logic [4:0] value;
        logic [15:0] addr;
        int k;
        region = 2'($urandom);
        value  = 5'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            offer_random(bus_access(REQ_PRG_WRITE, {1'b1, 15'($urandom)},
                                    {1'b1, 7'($urandom)}));
            sent++;
        end
        for (k = 0; k < 5; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                offer_random(bus_access(REQ_PRG_READ, 16'($urandom), 8'($urandom)));
                sent++;
            end
            if ($urandom_range(0, 24) == 0)
            begin
                offer_random(bus_access(REQ_PRG_WRITE, {1'b1, 15'($urandom)},
                                        {1'b1, 7'($urandom)}));
                sent++;
            end
            addr = {1'b1, region, 13'($urandom)};
            offer_random(bus_access(REQ_PRG_WRITE, addr, {1'b0, 6'($urandom), value[k]}));
            sent++;
        end
    endtask

    // let everything in flight come out before touching a register
    task automatic settle();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // one write strobe, with cfg_write low again before returning, so back-to-back calls never overlap
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int i;
        int phase;
        int sent;
        int pick;
        logic [4:0] banks;
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_PRG_BANK_COUNT;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        typed_valid  <= 1'b0;
        typed_result <= '0;
        calm         = 1'b0;
        pressing     = 1'b0;
        hold_off_req = 1'b0;
        reset_shadow();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table on reset register values
        for (i = 0; i < DIRECTED_ROWS; i++)
            offer(directed[i].access, directed[i].typed, directed[i].result);

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            // last phase runs with no idling on either side
            if (phase == PHASES - 1)
                calm = 1'b1;
            banks = (phase == 6) ? 5'($urandom_range(2, 15)) : PHASE_BANKS[phase];
            write_register(CFG_PRG_BANK_COUNT, banks);
            // upper data bits are don't-care for the ram flag
            write_register(CFG_CHR_USES_RAM, {4'($urandom), PHASE_RAM[phase]});
            settings_count++;

            sent = 0;
            if (phase == 3)
            begin
                // back-to-back offers against a long receiver hold-off
                hold_off_req = 1'b1;
                pressing     = 1'b1;
                for (i = 0; i < PRESSURE_RUN; i++)
                begin
                    offer_random(bus_access(REQ_PRG_READ, {1'b1, 15'($urandom)}, 8'($urandom)));
                    sent++;
                end
                pressing = 1'b0;
            end

            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    serial_load(sent);
                else if (pick < 65)
                begin
                    offer_random(bus_access(REQ_PRG_READ,
                        $urandom_range(0, 1) ? {1'b1, 15'($urandom)} : 16'($urandom),
                        8'($urandom)));
                    sent++;
                end
                else if (pick < 85)
                begin
                    offer_random(bus_access($urandom_range(0, 1) ? REQ_CHR_READ : REQ_CHR_WRITE,
                        ($urandom_range(0, 4) == 0) ? 16'($urandom) : {3'b000, 13'($urandom)},
                        8'($urandom)));
                    sent++;
                end
                else
                begin
                    // unconstrained cpu writes: restarts, ignored low writes, stray bits
                    offer_random(bus_access(REQ_PRG_WRITE, 16'($urandom), 8'($urandom)));
                    sent++;
                end
            end
        end

        settle();
        if (pending_results.size() != 0)
            report_fault("results never delivered", 0, pending_results.size());

        $display("ran %0d accesses (%0d results checked) over %0d register settings",
                 accepted_count, checked_count, settings_count);
        $display("saw %0d control loads and %0d cycles of input stall",
                 control_loads, stall_cycles);
        if (fault_count == 0)
            $display("serial_bank_switch_mapper_core verification clean");
        else
            $display("serial_bank_switch_mapper_core verification failed");
        $finish;
    end

endmodule

[serial_bank_switch_mapper_core.f]
+incdir+hw/rtl
hw/rtl/sbsm_pkg.sv
hw/rtl/sbsm_map.sv
hw/rtl/serial_bank_switch_mapper_core.sv
hw/rtl/sbsm_checker.sv
tb/serial_bank_switch_mapper_core_test.sv
